FILE: rtl/core/linear_interp_upsampler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation upsampler
// Clocked assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_UPSAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_UPSAMPLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/liu_pkg.sv
// ----------------------------------------------------------------------------
// liu_pkg
// Shared widths, constants, state types and divider interface structs.
// ----------------------------------------------------------------------------
package liu_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 8;
    localparam int FACTOR_WIDTH  = 15;

    localparam logic [FACTOR_WIDTH-1:0] FACTOR_MIN   = FACTOR_WIDTH'(1 << FRACTION_BITS);
    localparam logic [FACTOR_WIDTH-1:0] FACTOR_MAX   = FACTOR_WIDTH'(64 << FRACTION_BITS);
    localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = FACTOR_WIDTH'(2 << FRACTION_BITS);

    // run length d is 1..64, the index j 1..63
    localparam int D_WIDTH    = 7;
    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    // |diff * j| < 2^16 * 2^6
    localparam int MAG_WIDTH  = SAMPLE_WIDTH + D_WIDTH - 1;
    localparam int NUM_WIDTH  = MAG_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_LAST
    } seq_state_t;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    typedef struct packed {
        logic                 start;
        logic [MAG_WIDTH-1:0] dividend;
        logic [D_WIDTH-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [MAG_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/core/linear_interp_upsampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler_top
// Stretches a PCM stream by a Q7.8 factor, filling gaps by linear interpolation.
//
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  input     | in_valid, in_stall, in_sample, first_sample | in
//  output    | out_valid, out_stall, out_sample, run_last  | out
//  config    | cfg_we, stretch_factor                      | in
//
// For an input beat with a run of d outputs, each interpolated point runs
// one 22-step pass through the shared divider.
// A first_sample beat or a run of one bypasses the divider.
// in_stall is high from acceptance until the run's last output is registered.
// out_stall holds the output register and the sequencer; reset puts factor at 2.0.
// ----------------------------------------------------------------------------
`include "linear_interp_upsampler_top_assert.svh"

module linear_interp_upsampler_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [liu_pkg::FACTOR_WIDTH-1:0]        stretch_factor,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [liu_pkg::SAMPLE_WIDTH-1:0] in_sample,
    input  logic                                    first_sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [liu_pkg::SAMPLE_WIDTH-1:0] out_sample,
    output logic                                    run_last
);

    liu_pkg::seq_state_t state_reg, state_next;

    logic [liu_pkg::FACTOR_WIDTH-1:0]         factor_reg, factor_next;
    logic signed [liu_pkg::SAMPLE_WIDTH-1:0]  prev_reg, prev_next;
    logic [liu_pkg::FRACTION_BITS-1:0]        frac_reg, frac_next;
    logic signed [liu_pkg::SAMPLE_WIDTH-1:0]  base_reg, base_next;
    logic signed [liu_pkg::SAMPLE_WIDTH-1:0]  smp_reg, smp_next;
    logic signed [liu_pkg::DIFF_WIDTH-1:0]    diff_reg, diff_next;
    logic signed [liu_pkg::NUM_WIDTH-1:0]     num_reg, num_next;
    logic [liu_pkg::D_WIDTH-1:0]              j_reg, j_next;
    logic [liu_pkg::D_WIDTH-1:0]              d_reg, d_next;
    logic signed [liu_pkg::SAMPLE_WIDTH-1:0]  res_reg, res_next;
    logic                                     out_valid_reg, out_valid_next;
    logic signed [liu_pkg::SAMPLE_WIDTH-1:0]  out_sample_reg, out_sample_next;
    logic                                     run_last_reg, run_last_next;

    logic [liu_pkg::FACTOR_WIDTH-1:0]         factor_clamped;
    logic [liu_pkg::FACTOR_WIDTH-1:0]         pos_sum;
    logic signed [liu_pkg::DIFF_WIDTH-1:0]    diff_new;
    logic [liu_pkg::NUM_WIDTH-1:0]            num_mag;
    logic signed [liu_pkg::DIFF_WIDTH-1:0]    quo_signed;
    logic signed [liu_pkg::DIFF_WIDTH-1:0]    interp_sum;
    logic                                     in_take;
    logic                                     slot_free;

    liu_pkg::div_req_t div_req;
    liu_pkg::div_rsp_t div_rsp;

    liu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= liu_pkg::ST_IDLE;
            factor_reg    <= liu_pkg::FACTOR_RESET;
            prev_reg      <= '0;
            frac_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            prev_reg      <= prev_next;
            frac_reg      <= frac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        smp_reg        <= smp_next;
        diff_reg       <= diff_next;
        num_reg        <= num_next;
        j_reg          <= j_next;
        d_reg          <= d_next;
        res_reg        <= res_next;
        out_sample_reg <= out_sample_next;
        run_last_reg   <= run_last_next;
    end

    always_comb
    begin
        if (factor_reg < liu_pkg::FACTOR_MIN)
            factor_clamped = liu_pkg::FACTOR_MIN;
        else if (factor_reg > liu_pkg::FACTOR_MAX)
            factor_clamped = liu_pkg::FACTOR_MAX;
        else
            factor_clamped = factor_reg;
    end

    assign pos_sum   = liu_pkg::FACTOR_WIDTH'(frac_reg) + factor_clamped;
    assign diff_new  = liu_pkg::DIFF_WIDTH'(in_sample) - liu_pkg::DIFF_WIDTH'(prev_reg);
    assign num_mag   = num_reg[liu_pkg::NUM_WIDTH-1] ? (-num_reg) : num_reg;
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // quotient magnitude is below |diff|, so 16 bits hold it
    assign quo_signed = num_reg[liu_pkg::NUM_WIDTH-1]
        ? -$signed({1'b0, div_rsp.quotient[liu_pkg::SAMPLE_WIDTH-1:0]})
        :  $signed({1'b0, div_rsp.quotient[liu_pkg::SAMPLE_WIDTH-1:0]});
    assign interp_sum = liu_pkg::DIFF_WIDTH'(base_reg) + quo_signed;

    assign div_req.start    = (state_reg == liu_pkg::ST_DIV_START);
    assign div_req.dividend = num_mag[liu_pkg::MAG_WIDTH-1:0];
    assign div_req.divisor  = d_reg;

    always_comb
    begin
        state_next      = state_reg;
        factor_next     = cfg_we ? stretch_factor : factor_reg;
        prev_next       = prev_reg;
        frac_next       = frac_reg;
        base_next       = base_reg;
        smp_next        = smp_reg;
        diff_next       = diff_reg;
        num_next        = num_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_sample_next = out_sample_reg;
        run_last_next   = run_last_reg;

        case (state_reg)
            liu_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    smp_next  = in_sample;
                    prev_next = in_sample;
                    base_next = prev_reg;
                    if (first_sample)
                    begin
                        frac_next  = '0;
                        state_next = liu_pkg::ST_LAST;
                    end
                    else
                    begin
                        frac_next = pos_sum[liu_pkg::FRACTION_BITS-1:0];
                        d_next    = pos_sum[liu_pkg::FACTOR_WIDTH-1:liu_pkg::FRACTION_BITS];
                        diff_next = diff_new;
                        num_next  = liu_pkg::NUM_WIDTH'(diff_new);
                        j_next    = liu_pkg::D_WIDTH'(1);
                        if (pos_sum[liu_pkg::FACTOR_WIDTH-1:liu_pkg::FRACTION_BITS]
                            == liu_pkg::D_WIDTH'(1))
                            state_next = liu_pkg::ST_LAST;
                        else
                            state_next = liu_pkg::ST_DIV_START;
                    end
                end
            end
            liu_pkg::ST_DIV_START:
            begin
                state_next = liu_pkg::ST_DIV_WAIT;
            end
            liu_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next   = interp_sum[liu_pkg::SAMPLE_WIDTH-1:0];
                    state_next = liu_pkg::ST_EMIT;
                end
            end
            liu_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_reg;
                    run_last_next   = 1'b0;
                    j_next          = j_reg + 1'b1;
                    num_next        = num_reg + liu_pkg::NUM_WIDTH'(diff_reg);
                    if (j_reg + 1'b1 == d_reg)
                        state_next = liu_pkg::ST_LAST;
                    else
                        state_next = liu_pkg::ST_DIV_START;
                end
            end
            liu_pkg::ST_LAST:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = smp_reg;
                    run_last_next   = 1'b1;
                    state_next      = liu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = liu_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != liu_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;

    `ASSERT_NEXT(a_first_goes_last, clk, rst_n, in_valid && !in_stall && first_sample,
        state_reg == liu_pkg::ST_LAST,
        "first-sample beat did not go straight to the final output")
    `ASSERT_IMPLIES(a_done_only_waiting, clk, rst_n, div_rsp.done,
        state_reg == liu_pkg::ST_DIV_WAIT, "divider finished outside the wait state")
    `ASSERT_IMPLIES(a_index_in_run, clk, rst_n,
        state_reg == liu_pkg::ST_DIV_START || state_reg == liu_pkg::ST_DIV_WAIT
            || state_reg == liu_pkg::ST_EMIT,
        j_reg != '0 && j_reg < d_reg, "interpolation index outside run")

endmodule

FILE: rtl/core/liu_div.sv
// ----------------------------------------------------------------------------
// liu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "linear_interp_upsampler_top_assert.svh"

module liu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  liu_pkg::div_req_t req,
    output liu_pkg::div_rsp_t rsp
);

    liu_pkg::div_state_t state_reg, state_next;
    logic                               done_reg, done_next;
    logic [liu_pkg::CNT_WIDTH-1:0]      cnt_reg, cnt_next;
    logic [liu_pkg::D_WIDTH-1:0]        rem_reg, rem_next;
    logic [liu_pkg::D_WIDTH-1:0]        dvs_reg, dvs_next;
    logic [liu_pkg::MAG_WIDTH-1:0]      quo_reg, quo_next;
    logic [liu_pkg::D_WIDTH-1:0]        trial;
    logic                               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= liu_pkg::DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        // remainder stays below the divisor (<= 64), so its top bit is free
        trial      = {rem_reg[liu_pkg::D_WIDTH-2:0], quo_reg[liu_pkg::MAG_WIDTH-1]};
        fits       = (trial >= dvs_reg);
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        case (state_reg)
            liu_pkg::DIV_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = '0;
                    quo_next   = req.dividend;
                    dvs_next   = req.divisor;
                    cnt_next   = '0;
                    state_next = liu_pkg::DIV_RUN;
                end
            end
            liu_pkg::DIV_RUN:
            begin
                rem_next = fits ? (trial - dvs_reg) : trial;
                quo_next = {quo_reg[liu_pkg::MAG_WIDTH-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == liu_pkg::CNT_WIDTH'(liu_pkg::MAG_WIDTH - 1))
                begin
                    state_next = liu_pkg::DIV_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = liu_pkg::DIV_IDLE;
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `ASSERT_IMPLIES(a_rem_below_divisor, clk, rst_n, state_reg == liu_pkg::DIV_RUN,
        rem_reg < dvs_reg, "divider remainder not below divisor")
    `ASSERT_IMPLIES(a_start_when_idle, clk, rst_n, req.start,
        state_reg == liu_pkg::DIV_IDLE, "divider started while busy")
    `ASSERT_NEXT(a_done_single_pulse, clk, rst_n, done_reg, !done_reg,
        "divider done held longer than one cycle")

endmodule
